// ===== hw/rtl/utf8_to_utf16_decoder_unit_defines.svh =====
// Assertion helpers for the checker file.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define U8U16_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam logic [7:0]  CONT_FLAG   = 8'h80;
   localparam logic [7:0]  LEAD3_MASK  = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
   localparam logic [7:0]  LEAD4_MASK  = 8'hF0;
   localparam logic [7:0]  LEAD2_BITS  = 8'h1F;
   localparam logic [7:0]  LEAD3_BITS  = 8'h0F;
   localparam logic [7:0]  CONT_BITS   = 8'h3F;
   localparam logic [15:0] REPLACEMENT = 16'h003F;

   localparam logic [1:0]  PEND_NONE   = 2'd0;
   localparam logic [1:0]  PEND_ONE    = 2'd1;
   localparam logic [1:0]  PEND_TWO    = 2'd2;
   localparam logic [1:0]  PEND_SKIP   = 2'd3;

   typedef struct packed {
      logic        emit;
      logic [15:0] code_unit;
      logic        is_end;
   } result_type;

endpackage

// ===== hw/rtl/utf8_to_utf16_decoder_unit.sv =====
`timescale 1ns / 1ps
// UTF-8 to UTF-16 decoder (Basic Multilingual Plane).
// req channel: one raw byte of a NUL-terminated UTF-8 string per transfer.
// rsp channel: one UTF-16 code unit per transfer; rsp_is_end marks the
// terminating zero. Bytes 2..n of a multi-byte sequence give no transfer;
// the code unit leaves after the last byte. Leads 0x80..0xBF and 0xF0..0xFF
// give '?' at once and the next three bytes are dropped.
// Throughput: one byte per cycle while rsp_stall does not hold back a
// result. After the edge that takes a sequence's last byte, that byte waits
// in the input register, then the decode step writes the output register,
// which raises rsp_valid.
// Stall: while rsp_stall holds a valid result, the output register keeps it,
// the input register can still take one byte, and req_stall rises only once
// that byte is waiting on the blocked output register.
// Reset (synchronous): both registers empty, no sequence in progress.
module utf8_to_utf16_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_is_end
);
   import u8u16_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_code_ff;
   logic        rsp_end_ff;
   logic        advance;
   logic        accept;
   result_type  result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   u8u16_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_value (in_byte_ff),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_byte_value;
      end
      if (advance && result.emit) begin
         rsp_code_ff <= result.code_unit;
         rsp_end_ff  <= result.is_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_unit = rsp_code_ff;
   assign rsp_is_end    = rsp_end_ff;

endmodule

// ===== hw/rtl/u8u16_decode.sv =====
`timescale 1ns / 1ps

module u8u16_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            byte_value,
   output u8u16_pkg::result_type result
);
   import u8u16_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [15:0] bits_ff, bits_in;
   logic        skip_ff, skip_in;
   result_type  res;

   always_comb begin
      pending_in = pending_ff;
      bits_in    = bits_ff;
      skip_in    = skip_ff;
      res        = '0;
      if (advance) begin
         if (pending_ff != PEND_NONE) begin
            pending_in = pending_ff - 2'd1;
            if (skip_ff) begin
               if (pending_in == PEND_NONE) begin
                  skip_in = 1'b0;
               end
            end else if (pending_in == PEND_ONE) begin
               bits_in = bits_ff | {4'b0, byte_value[5:0], 6'b0};
            end else begin
               bits_in       = bits_ff | {10'b0, byte_value[5:0]};
               res.emit      = 1'b1;
               res.code_unit = bits_in;
            end
         end else if (byte_value == 8'h00) begin
            res.emit   = 1'b1;
            res.is_end = 1'b1;
         end else if ((byte_value & CONT_FLAG) == 8'h00) begin
            res.emit      = 1'b1;
            res.code_unit = {8'b0, byte_value};
         end else if ((byte_value & LEAD3_MASK) == LEAD2_CODE) begin
            bits_in    = {5'b0, byte_value[4:0], 6'b0};
            pending_in = PEND_ONE;
         end else if ((byte_value & LEAD4_MASK) == LEAD3_MASK) begin
            bits_in    = {byte_value[3:0], 12'b0};
            pending_in = PEND_TWO;
         end else begin
            // bad lead: replace it and drop the next three bytes
            skip_in       = 1'b1;
            pending_in    = PEND_SKIP;
            bits_in       = '0;
            res.emit      = 1'b1;
            res.code_unit = REPLACEMENT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         bits_ff    <= '0;
         skip_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         bits_ff    <= bits_in;
         skip_ff    <= skip_in;
      end
   end

   assign result = res;

endmodule

// ===== hw/rtl/u8u16_checker.sv =====
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_unit_defines.svh"

module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_is_end
);

   // a held result must not change
   `U8U16_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_code_unit) && $stable(rsp_is_end),
      "rsp changed while stalled")

   // the end mark only ever carries code unit zero
   `U8U16_ASSERT(a_end_zero, clock, reset,
      rsp_valid && rsp_is_end |-> rsp_code_unit == 16'h0000,
      "end mark with nonzero code unit")

   // backpressure on req only comes from a blocked result
   `U8U16_ASSERT(a_stall_cause, clock, reset,
      req_stall |-> rsp_valid && rsp_stall,
      "req stalled with free output")

   // nothing to deliver right after reset
   `U8U16_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid,
      "rsp valid after reset")

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_u8u16_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_code_unit (rsp_code_unit),
   .rsp_is_end    (rsp_is_end)
);
